// ===== hw/rtl/hrkd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrkd_pkg
// Shared types, constants and the key code lookup for the HID report differ.
// ----------------------------------------------------------------------------
package hrkd_pkg;

  // report geometry
  localparam int KeySlots     = 6;
  localparam int SlotW        = $clog2(KeySlots);
  localparam int ModBits      = 8;
  localparam int Steps        = ModBits + 2 * KeySlots;
  localparam int StepW        = $clog2(Steps);
  localparam int MaskW        = 12;
  localparam int QueueDepthDef = 4;

  localparam logic [7:0] IgnoreMax   = 8'd3;
  localparam logic [7:0] ModScanBase = 8'd224;

  // modifier byte bit -> mask bit
  localparam logic [MaskW-1:0] ModMask [ModBits] = '{
    12'h040, 12'h001, 12'h100, 12'h400, 12'h080, 12'h002, 12'h200, 12'h800
  };

  // codes for usage 40..56, zero falls back to the flagged scan code
  localparam int PunctBase = 40;
  localparam int PunctLen  = 17;
  localparam logic [7:0] PunctCode [PunctLen] = '{
    8'd13, 8'd27, 8'd8, 8'd9, 8'd32, 8'd45, 8'd61, 8'd91, 8'd93, 8'd92,
    8'd0, 8'd59, 8'd39, 8'd96, 8'd44, 8'd46, 8'd47
  };

  typedef logic [KeySlots-1:0][7:0] keys_t;

  // one key event word between front and back
  typedef struct packed {
    logic             pressed;
    logic [7:0]       scan_code;
    logic [MaskW-1:0] mask;
    logic             last;
  } event_t;

  // scan code -> key code
  function automatic logic [30:0] key_code_for(logic [7:0] sc);
    logic [7:0] pc;
    logic [30:0] res;
    pc = 8'd0;
    if (sc inside {[8'd40:8'd56]}) begin
      pc = PunctCode[5'(sc - 8'd40)];
    end
    if (sc inside {[8'd4:8'd29]}) begin
      res = {23'd0, sc + 8'd93};
    end else if (sc inside {[8'd30:8'd38]}) begin
      res = {23'd0, sc + 8'd19};
    end else if (sc == 8'd39) begin
      res = 31'd48;
    end else if (pc != 8'd0) begin
      res = {23'd0, pc};
    end else begin
      res = {1'b1, 22'd0, sc};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/hrkd_front.sv =====
// ----------------------------------------------------------------------------
// hrkd_front
// Accepts a report, flags every event it causes against the stored previous
// report, then walks candidates one per cycle into the queue unless full.
// ----------------------------------------------------------------------------
module hrkd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       mods_i,
  input  hrkd_pkg::keys_t  keys_i,
  output logic             push_valid_o,
  output hrkd_pkg::event_t push_word_o,
  input  logic             push_full_i
);
  import hrkd_pkg::*;

  logic                   busy_q, busy_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [Steps-1:0]       flags_q, flags_d, flags_new;
  logic [7:0]             mods_q, mods_d;
  keys_t                  keys_q, keys_d;
  keys_t                  old_q, old_d;
  logic [MaskW-1:0]       mask_q, mask_d;

  logic [KeySlots-1:0]    rel_hit, pr_hit;
  logic                   accept, want, advance, is_mod, is_rel, mod_down;
  logic [2:0]             mod_sel;
  logic [StepW-1:0]       rel_off, pr_off;
  logic [SlotW-1:0]       rel_idx, pr_idx;
  logic [MaskW-1:0]       mask_mod;
  logic [Steps-1:0]       rest;

  // candidate events of the incoming report
  always_comb begin
    rel_hit = '0;
    pr_hit  = '0;
    for (int j = 0; j < KeySlots; j++) begin
      for (int k = 0; k < KeySlots; k++) begin
        if (keys_i[k] == keys_q[j]) rel_hit[j] = 1'b1;
        if (keys_q[k] == keys_i[j]) pr_hit[j]  = 1'b1;
      end
    end
    flags_new = '0;
    flags_new[ModBits-1:0] = mods_i ^ mods_q;
    for (int j = 0; j < KeySlots; j++) begin
      flags_new[ModBits+j]          = (keys_q[j] > IgnoreMax) && !rel_hit[j];
      flags_new[ModBits+KeySlots+j] = (keys_i[j] > IgnoreMax) && !pr_hit[j];
    end
  end

  // step decode
  assign mod_sel = step_q[2:0];
  assign is_mod  = step_q < StepW'(ModBits);
  assign is_rel  = step_q < StepW'(ModBits + KeySlots);
  assign rel_off = step_q - StepW'(ModBits);
  assign pr_off  = step_q - StepW'(ModBits + KeySlots);
  assign rel_idx = rel_off[SlotW-1:0];
  assign pr_idx  = pr_off[SlotW-1:0];
  assign mod_down = mods_q[mod_sel];
  assign mask_mod = mod_down ? (mask_q | ModMask[mod_sel]) : (mask_q & ~ModMask[mod_sel]);

  assign rest = flags_q >> step_q;

  assign accept  = in_valid_i && !busy_q;
  assign want    = busy_q && flags_q[step_q];
  assign advance = busy_q && (!want || !push_full_i);

  assign in_stall_o   = busy_q;
  assign push_valid_o = want;

  // event word for the current step
  always_comb begin
    push_word_o.last = ~|rest[Steps-1:1];
    if (is_mod) begin
      push_word_o.pressed   = mod_down;
      push_word_o.scan_code = ModScanBase + {5'd0, mod_sel};
      push_word_o.mask      = mask_mod;
    end else if (is_rel) begin
      push_word_o.pressed   = 1'b0;
      push_word_o.scan_code = old_q[rel_idx];
      push_word_o.mask      = mask_q;
    end else begin
      push_word_o.pressed   = 1'b1;
      push_word_o.scan_code = keys_q[pr_idx];
      push_word_o.mask      = mask_q;
    end
  end

  // sequencer
  always_comb begin
    busy_d  = busy_q;
    step_d  = step_q;
    flags_d = flags_q;
    mods_d  = mods_q;
    keys_d  = keys_q;
    old_d   = old_q;
    mask_d  = mask_q;
    if (accept) begin
      busy_d  = 1'b1;
      step_d  = '0;
      flags_d = flags_new;
      mods_d  = mods_i;
      keys_d  = keys_i;
      old_d   = keys_q;
    end else if (advance) begin
      if (want && is_mod) mask_d = mask_mod;
      if (step_q == StepW'(Steps - 1)) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      step_q  <= '0;
      flags_q <= '0;
      mods_q  <= '0;
      keys_q  <= '0;
      mask_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      step_q  <= step_d;
      flags_q <= flags_d;
      mods_q  <= mods_d;
      keys_q  <= keys_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    old_q <= old_d;
  end

endmodule

// ===== hw/rtl/hrkd_queue.sv =====
// ----------------------------------------------------------------------------
// hrkd_queue
// Small FIFO of event words between the front sequencer and the back end.
// ----------------------------------------------------------------------------
module hrkd_queue #(
  parameter int QueueDepth = hrkd_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  hrkd_pkg::event_t push_word_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output hrkd_pkg::event_t pop_word_o
);
  import hrkd_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  event_t            mem_q [QueueDepth];
  event_t            head_q;
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign full_o     = cnt_q == CntW'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign push       = push_valid_i && !full_o;
  assign pop        = pop_i && !empty_o;
  assign pop_word_o = head_q;

  // pointers wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    if (pop)  rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    if (push && !pop)      cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage; head word registered, a write to the next head slot is forwarded
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_word_i;
    if (push && wr_q == rd_d) head_q <= push_word_i;
    else head_q <= mem_q[rd_d];
  end

endmodule

// ===== hw/rtl/hrkd_back.sv =====
// ----------------------------------------------------------------------------
// hrkd_back
// Pops event words, maps the scan code to a key code and holds the result
// in the output register until it is taken.
// ----------------------------------------------------------------------------
module hrkd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  hrkd_pkg::event_t               word_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           pressed_o,
  output logic [7:0]                     scan_code_o,
  output logic [30:0]                    key_code_o,
  output logic [hrkd_pkg::MaskW-1:0]     modifier_mask_o,
  output logic                           last_event_o
);
  import hrkd_pkg::*;

  logic             valid_q, valid_d;
  logic             pressed_q;
  logic [7:0]       scan_q;
  logic [30:0]      code_q;
  logic [MaskW-1:0] mask_q;
  logic             last_q;
  logic             load;

  // refill when the register is empty or being taken
  assign load    = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o   = load;
  assign valid_d = load ? 1'b1 : (out_stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pressed_q <= word_i.pressed;
      scan_q    <= word_i.scan_code;
      code_q    <= key_code_for(word_i.scan_code);
      mask_q    <= word_i.mask;
      last_q    <= word_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign pressed_o       = pressed_q;
  assign scan_code_o     = scan_q;
  assign key_code_o      = code_q;
  assign modifier_mask_o = mask_q;
  assign last_event_o    = last_q;

endmodule

// ===== hw/rtl/hid_report_key_event_diff.sv =====
// ----------------------------------------------------------------------------
// hid_report_key_event_diff
// HID boot keyboard report to key event converter (top level).
// ----------------------------------------------------------------------------
// A report (modifier byte and six key slots) is taken when in_valid_i is high
// and in_stall_o is low. It is diffed against the previous report and gives
// zero to twenty key event words: changed modifier bits first (bit 0 up),
// then releases of held keys in slot order, then new presses in slot order;
// last_event_o marks the final word of a report. The front sequencer walks
// all twenty candidate event positions one per cycle while the event queue
// is not full, and keeps in_stall_o high until the walk is done. Words leave
// at up to one per cycle while out_stall_i is low, through a registered
// output; the queue depth is set by QueueDepth.
// ----------------------------------------------------------------------------
module hid_report_key_event_diff #(
  parameter int QueueDepth = hrkd_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 modifier_bits_i,
  input  logic [7:0]                 key_slot_0_i,
  input  logic [7:0]                 key_slot_1_i,
  input  logic [7:0]                 key_slot_2_i,
  input  logic [7:0]                 key_slot_3_i,
  input  logic [7:0]                 key_slot_4_i,
  input  logic [7:0]                 key_slot_5_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       pressed_o,
  output logic [7:0]                 scan_code_o,
  output logic [30:0]                key_code_o,
  output logic [hrkd_pkg::MaskW-1:0] modifier_mask_o,
  output logic                       last_event_o
);
  import hrkd_pkg::*;

  keys_t  keys;
  event_t push_word, pop_word;
  logic   push_valid, full, empty, pop;

  assign keys = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                 key_slot_2_i, key_slot_1_i, key_slot_0_i};

  // report intake and event sequencing
  hrkd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mods_i       (modifier_bits_i),
    .keys_i       (keys),
    .push_valid_o (push_valid),
    .push_word_o  (push_word),
    .push_full_i  (full)
  );

  // event word queue
  hrkd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_word_i  (push_word),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .pop_word_o   (pop_word)
  );

  // key code mapping and output register
  hrkd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .word_i          (pop_word),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pressed_o       (pressed_o),
    .scan_code_o     (scan_code_o),
    .key_code_o      (key_code_o),
    .modifier_mask_o (modifier_mask_o),
    .last_event_o    (last_event_o)
  );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HID report to key event differ.
// ----------------------------------------------------------------------------
// Reports are sent through the valid/stall input channel. A behavioral
// predictor diffs each accepted report against its own copy of the previous
// report. It queues the key event words that should come out. Every word
// taken from the output channel is compared with the oldest queued word.
// Both channels idle in random bursts, except in some random stretches and the closing one.
// ----------------------------------------------------------------------------
module testbench;

  import hrkd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 30;

  // expected key event word
  typedef struct packed {
    logic             pressed;
    logic [7:0]       scan_code;
    logic [30:0]      key_code;
    logic [MaskW-1:0] mask;
    logic             last_ev;
  } key_event_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             in_valid_i      = 1'b0;
  logic             in_stall_o;
  logic [7:0]       modifier_bits_i = 8'd0;
  logic [7:0]       key_slot_0_i    = 8'd0;
  logic [7:0]       key_slot_1_i    = 8'd0;
  logic [7:0]       key_slot_2_i    = 8'd0;
  logic [7:0]       key_slot_3_i    = 8'd0;
  logic [7:0]       key_slot_4_i    = 8'd0;
  logic [7:0]       key_slot_5_i    = 8'd0;
  logic             out_valid_o;
  logic             out_stall_i     = 1'b0;
  logic             pressed_o;
  logic [7:0]       scan_code_o;
  logic [30:0]      key_code_o;
  logic [MaskW-1:0] modifier_mask_o;
  logic             last_event_o;

  // predictor state: what the block should hold after each accepted report
  logic [7:0]       held_mods = 8'd0;
  keys_t            held_keys = '0;
  logic [MaskW-1:0] held_mask = '0;

  key_event_t events_due[$];
  int         errors     = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  bit         idle_en    = 1'b1;

  // current report for the random phase
  logic [7:0] cur_mods;
  keys_t      cur_keys;

  hid_report_key_event_diff dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .modifier_bits_i(modifier_bits_i),
    .key_slot_0_i   (key_slot_0_i),
    .key_slot_1_i   (key_slot_1_i),
    .key_slot_2_i   (key_slot_2_i),
    .key_slot_3_i   (key_slot_3_i),
    .key_slot_4_i   (key_slot_4_i),
    .key_slot_5_i   (key_slot_5_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pressed_o      (pressed_o),
    .scan_code_o    (scan_code_o),
    .key_code_o     (key_code_o),
    .modifier_mask_o(modifier_mask_o),
    .last_event_o   (last_event_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // modifier byte bit -> mask bit
  function automatic logic [MaskW-1:0] mask_for_mod(input int idx);
    case (idx)
      0: return 12'h040;  // left ctrl
      1: return 12'h001;  // left shift
      2: return 12'h100;  // left alt
      3: return 12'h400;  // left gui
      4: return 12'h080;  // right ctrl
      5: return 12'h002;  // right shift
      6: return 12'h200;  // right alt
      default: return 12'h800;  // right gui
    endcase
  endfunction

  // usage code -> key code; unmapped codes get the flag bit
  function automatic logic [30:0] expected_key_code(input logic [7:0] sc);
    logic [30:0] code;
    code = {23'd0, sc} | 31'h4000_0000;
    if (sc >= 8'd4 && sc <= 8'd29) begin
      code = {23'd0, sc} + 31'd93;        // a..z
    end else if (sc >= 8'd30 && sc <= 8'd38) begin
      code = {23'd0, sc} + 31'd19;        // 1..9
    end else if (sc == 8'd39) begin
      code = 31'd48;                      // 0
    end else begin
      case (sc)
        8'd40: code = 31'd13;   // return
        8'd41: code = 31'd27;   // escape
        8'd42: code = 31'd8;    // backspace
        8'd43: code = 31'd9;    // tab
        8'd44: code = 31'd32;   // space
        8'd45: code = 31'd45;
        8'd46: code = 31'd61;
        8'd47: code = 31'd91;
        8'd48: code = 31'd93;
        8'd49: code = 31'd92;
        8'd51: code = 31'd59;   // 50 has no printable code
        8'd52: code = 31'd39;
        8'd53: code = 31'd96;
        8'd54: code = 31'd44;
        8'd55: code = 31'd46;
        8'd56: code = 31'd47;
        default: ;
      endcase
    end
    return code;
  endfunction

  function automatic bit holds_code(input keys_t keys, input logic [7:0] code);
    for (int i = 0; i < KeySlots; i++) begin
      if (keys[i] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void queue_event(input logic down, input logic [7:0] sc);
    key_event_t ev;
    ev.pressed   = down;
    ev.scan_code = sc;
    ev.key_code  = expected_key_code(sc);
    ev.mask      = held_mask;
    ev.last_ev   = 1'b0;
    events_due.push_back(ev);
  endfunction

  // diff one report against the held one and queue its events
  function automatic void predict_key_events(input logic [7:0] mods, input keys_t keys);
    int         first;
    logic [7:0] changed;
    first   = events_due.size();
    changed = mods ^ held_mods;
    for (int i = 0; i < ModBits; i++) begin
      if (changed[i]) begin
        if (mods[i]) held_mask = held_mask | mask_for_mod(i);
        else held_mask = held_mask & ~mask_for_mod(i);
        queue_event(mods[i], ModScanBase + 8'(i));
      end
    end
    // releases, then presses, both in slot order
    for (int i = 0; i < KeySlots; i++) begin
      if (held_keys[i] > IgnoreMax && !holds_code(keys, held_keys[i]))
        queue_event(1'b0, held_keys[i]);
    end
    for (int i = 0; i < KeySlots; i++) begin
      if (keys[i] > IgnoreMax && !holds_code(held_keys, keys[i]))
        queue_event(1'b1, keys[i]);
    end
    held_mods = mods;
    held_keys = keys;
    if (events_due.size() > first) events_due[events_due.size() - 1].last_ev = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // send one report word, with an optional gap ahead of it
  task automatic send_report(input logic [7:0] mods, input logic [7:0] s0,
                             input logic [7:0] s1, input logic [7:0] s2,
                             input logic [7:0] s3, input logic [7:0] s4,
                             input logic [7:0] s5);
    keys_t keys;
    keys = {s5, s4, s3, s2, s1, s0};
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    modifier_bits_i <= mods;
    key_slot_0_i    <= s0;
    key_slot_1_i    <= s1;
    key_slot_2_i    <= s2;
    key_slot_3_i    <= s3;
    key_slot_4_i    <= s4;
    key_slot_5_i    <= s5;
    do @(posedge clk_i); while (in_stall_o);
    predict_key_events(mods, keys);
  endtask

  // ---------------------------------------------------------------------------
  // output side: out_stall_i raised at random in bursts of cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!idle_en) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 11);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each accepted event word with the oldest expected one
  always @(posedge clk_i) begin
    key_event_t got;
    key_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{pressed_o, scan_code_o, key_code_o, modifier_mask_o, last_event_o};
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: pressed=%0b scan=%0d code=%h mask=%h last=%0b",
                 $time, got.pressed, got.scan_code, got.key_code, got.mask, got.last_ev);
      end else begin
        want = events_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected pressed=%0b scan=%0d code=%h mask=%h last=%0b",
                   $time, want.pressed, want.scan_code, want.key_code, want.mask,
                   want.last_ev);
          $display("%0t:           actual pressed=%0b scan=%0d code=%h mask=%h last=%0b",
                   $time, got.pressed, got.scan_code, got.key_code, got.mask, got.last_ev);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired, %0d words still expected", $time, events_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every modifier bit pressed and released
  task automatic test_modifier_bits();
    send_report(8'hFF, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_report(8'hA5, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_report(8'h5A, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // press, release, ignored codes, repeats and the unchanged report
  task automatic test_key_slots();
    send_report(8'h00, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_report(8'h00, 8'd4, 8'd29, 8'd30, 8'd38, 8'd39, 8'd40);
    send_report(8'h00, 8'd4, 8'd29, 8'd30, 8'd38, 8'd39, 8'd40);  // unchanged
    send_report(8'h00, 8'd1, 8'd2, 8'd3, 8'd0, 8'd255, 8'd50);
    send_report(8'h00, 8'd3, 8'd2, 8'd1, 8'd0, 8'd255, 8'd50);    // only ignored moved
    send_report(8'h00, 8'd30, 8'd30, 8'd56, 8'd57, 8'd0, 8'd0);   // repeated code
    send_report(8'h02, 8'd30, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // twenty events from one report: all modifiers and all slots change
  task automatic test_full_report();
    send_report(8'hFF, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 8'd46);
    send_report(8'h00, 8'd51, 8'd55, 8'd100, 8'd224, 8'd231, 8'd255);
    send_report(8'hFF, 8'd47, 8'd48, 8'd49, 8'd52, 8'd53, 8'd54);
    send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // mostly typing-like edits of the last report, some noise
  task automatic test_random_typing(input int count);
    int pick;
    int slot;
    cur_mods = held_mods;
    cur_keys = held_keys;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if (n >= count - 40) idle_en = 1'b0;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, KeySlots - 1);
      if (pick < 20) begin
        cur_mods = 8'($urandom);
        for (int i = 0; i < KeySlots; i++) cur_keys[i] = 8'($urandom);
      end else if (pick < 40) begin
        cur_mods[$urandom_range(0, ModBits - 1)] ^= 1'b1;
      end else if (pick < 70) begin
        cur_keys[slot] = 8'($urandom_range(4, 56));
      end else if (pick < 80) begin
        cur_keys[slot] = 8'd0;
      end else if (pick < 87) begin
        cur_keys[slot] = 8'($urandom_range(0, 3));
      end else if (pick < 94) begin
        cur_keys[slot] = cur_keys[$urandom_range(0, KeySlots - 1)];
      end else begin
        cur_mods = 8'd0;
        cur_keys = '0;
      end
      send_report(cur_mods, cur_keys[0], cur_keys[1], cur_keys[2], cur_keys[3],
                  cur_keys[4], cur_keys[5]);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_modifier_bits();
    test_key_slots();
    test_full_report();
    test_random_typing(230);

    in_valid_i <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
